FILE: src/prcrr_pkg.sv
// shared types, codes and constants of the round robin thread scheduler
package prcrr_pkg;

   localparam int DEF_MAX_CORES   = 16;
   localparam int DEF_MAX_THREADS = 64;
   localparam int CFG_W           = 5;

   localparam logic [2:0] OP_SPAWN   = 3'd0;
   localparam logic [2:0] OP_YIELD   = 3'd1;
   localparam logic [2:0] OP_FINISH  = 3'd2;
   localparam logic [2:0] OP_TICK    = 3'd3;
   localparam logic [2:0] OP_RELEASE = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INLINE   = 3'd1;
   localparam logic [2:0] ST_NOSLOT   = 3'd2;
   localparam logic [2:0] ST_NOCHANGE = 3'd3;
   localparam logic [2:0] ST_NOTDONE  = 3'd4;
   localparam logic [2:0] ST_INVALID  = 3'd5;

   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_READY   = 2'd1;
   localparam logic [1:0] SLOT_RUNNING = 2'd2;
   localparam logic [1:0] SLOT_DONE    = 2'd3;

   typedef struct packed {
      logic [2:0] operation;
      logic [3:0] core;
      logic [5:0] thread_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] new_thread;
      logic [3:0] target_core;
      logic       switch_valid;
      logic [5:0] switch_thread;
      logic       return_to_base;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_SC_RD, S_SC_CHK, S_SP_SET, S_SP_RDH, S_SP_W1, S_SP_W2,
      S_Y_RDME, S_Y_LD, S_Y_CHK, S_Y_TEST, S_SW, S_F_RDME, S_F_LD, S_F_CHK,
      S_F_TEST, S_F_FIX, S_FIND, S_R_RD, S_R_TEST, S_R_CHK, S_REL_RD, S_REL_TEST
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_START, CMD_READ, CMD_READ_HEAD, CMD_P_INC, CMD_SP_SET,
      CMD_SP_LINK1, CMD_SP_LINK2, CMD_P_ME, CMD_FIN_DONE, CMD_P_HEAD, CMD_P_TID,
      CMD_P_LINK, CMD_P_LINK_INC, CMD_Y_SW1, CMD_NXT_P, CMD_SW_RUN, CMD_FIN_LM,
      CMD_FIN_SOLO, CMD_FIN_FIX, CMD_BASE, CMD_REL
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       status_we;
      logic [2:0] status;
      logic       emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       inv_core;
      logic       tid_bad;
      logic       nc_le1;
      logic       run_pres;
      logic       ring_pres;
      logic       st_free;
      logic       slot_rdy;
      logic       st_done;
      logic       p_last;
      logic       p_eq_me;
      logic       n_max;
      logic       lnq_eq_me;
      logic       lnq_eq_head;
   } dp_flags_type;

endpackage

FILE: src/prcrr_ctrl.sv
// sequencing state machine of the thread scheduler
module prcrr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  prcrr_pkg::dp_flags_type flags,
   output prcrr_pkg::ctl_cmd_type cmd,
   output logic                   busy
);
   import prcrr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (flags.op)
               OP_SPAWN: begin
                  if (!flags.nc_le1) state_in = S_SC_RD;
               end
               OP_YIELD: begin
                  if (!flags.inv_core && flags.run_pres) state_in = S_Y_RDME;
               end
               OP_FINISH: begin
                  if (!flags.inv_core && flags.run_pres) state_in = S_F_RDME;
               end
               OP_TICK: begin
                  if (!flags.inv_core && !flags.run_pres && flags.ring_pres)
                     state_in = S_R_RD;
               end
               OP_RELEASE: begin
                  if (!flags.tid_bad) state_in = S_REL_RD;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SC_RD:  state_in = S_SC_CHK;
         S_SC_CHK: begin
            if (flags.st_free) state_in = S_SP_SET;
            else if (flags.p_last) state_in = S_IDLE;
            else state_in = S_SC_RD;
         end
         S_SP_SET: state_in = flags.ring_pres ? S_SP_RDH : S_IDLE;
         S_SP_RDH: state_in = S_SP_W1;
         S_SP_W1:  state_in = S_SP_W2;
         S_SP_W2:  state_in = S_IDLE;
         S_Y_RDME: state_in = S_Y_LD;
         S_Y_LD:   state_in = S_Y_CHK;
         S_Y_CHK:  state_in = (flags.n_max || flags.p_eq_me) ? S_IDLE : S_Y_TEST;
         S_Y_TEST: state_in = flags.slot_rdy ? S_SW : S_Y_CHK;
         S_SW:     state_in = S_IDLE;
         S_F_RDME: state_in = S_F_LD;
         S_F_LD:   state_in = flags.lnq_eq_me ? S_FIND : S_F_CHK;
         S_F_CHK:  state_in = flags.n_max ? S_F_FIX : S_F_TEST;
         S_F_TEST: state_in = flags.lnq_eq_me ? S_F_FIX : S_F_CHK;
         S_F_FIX:  state_in = S_FIND;
         S_FIND:   state_in = flags.ring_pres ? S_R_RD : S_IDLE;
         S_R_RD:   state_in = S_R_TEST;
         S_R_TEST: begin
            if (flags.slot_rdy) state_in = S_SW;
            else if (flags.lnq_eq_head) state_in = S_IDLE;
            else state_in = S_R_CHK;
         end
         S_R_CHK:    state_in = flags.n_max ? S_IDLE : S_R_RD;
         S_REL_RD:   state_in = S_REL_TEST;
         S_REL_TEST: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op        = CMD_NONE;
      cmd.status_we = 1'b0;
      cmd.status    = ST_OK;
      cmd.emit      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) cmd.op = CMD_START;
         end
         S_DECODE: begin
            case (flags.op)
               OP_SPAWN: begin
                  if (flags.nc_le1) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_INLINE;
                     cmd.emit      = 1'b1;
                  end
               end
               OP_YIELD: begin
                  if (flags.inv_core || !flags.run_pres) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = flags.inv_core ? ST_INVALID : ST_NOCHANGE;
                     cmd.emit      = 1'b1;
                  end else begin
                     cmd.op = CMD_P_ME;
                  end
               end
               OP_FINISH: begin
                  if (flags.inv_core || !flags.run_pres) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_INVALID;
                     cmd.emit      = 1'b1;
                  end else begin
                     cmd.op = CMD_FIN_DONE;
                  end
               end
               OP_TICK: begin
                  if (flags.inv_core) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_INVALID;
                     cmd.emit      = 1'b1;
                  end else if (flags.run_pres || !flags.ring_pres) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_NOCHANGE;
                     cmd.emit      = 1'b1;
                  end else begin
                     cmd.op = CMD_P_HEAD;
                  end
               end
               OP_RELEASE: begin
                  if (flags.tid_bad) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_INVALID;
                     cmd.emit      = 1'b1;
                  end else begin
                     cmd.op = CMD_P_TID;
                  end
               end
               default: begin
                  cmd.status_we = 1'b1;
                  cmd.status    = ST_INVALID;
                  cmd.emit      = 1'b1;
               end
            endcase
         end
         S_SC_RD: cmd.op = CMD_READ;
         S_SC_CHK: begin
            if (!flags.st_free) begin
               if (flags.p_last) begin
                  cmd.status_we = 1'b1;
                  cmd.status    = ST_NOSLOT;
                  cmd.emit      = 1'b1;
               end else begin
                  cmd.op = CMD_P_INC;
               end
            end
         end
         S_SP_SET: begin
            cmd.op   = CMD_SP_SET;
            cmd.emit = !flags.ring_pres;
         end
         S_SP_RDH: cmd.op = CMD_READ_HEAD;
         S_SP_W1:  cmd.op = CMD_SP_LINK1;
         S_SP_W2: begin
            cmd.op   = CMD_SP_LINK2;
            cmd.emit = 1'b1;
         end
         S_Y_RDME: cmd.op = CMD_READ;
         S_Y_LD:   cmd.op = CMD_P_LINK;
         S_Y_CHK: begin
            if (flags.n_max || flags.p_eq_me) begin
               cmd.status_we = 1'b1;
               cmd.status    = ST_NOCHANGE;
               cmd.emit      = 1'b1;
            end else begin
               cmd.op = CMD_READ;
            end
         end
         S_Y_TEST: cmd.op = flags.slot_rdy ? CMD_Y_SW1 : CMD_P_LINK_INC;
         S_SW: begin
            cmd.op   = CMD_SW_RUN;
            cmd.emit = 1'b1;
         end
         S_F_RDME: cmd.op = CMD_READ;
         S_F_LD:   cmd.op = flags.lnq_eq_me ? CMD_FIN_SOLO : CMD_FIN_LM;
         S_F_CHK: begin
            if (!flags.n_max) cmd.op = CMD_READ;
         end
         S_F_TEST: begin
            if (!flags.lnq_eq_me) cmd.op = CMD_P_LINK_INC;
         end
         S_F_FIX: cmd.op = CMD_FIN_FIX;
         S_FIND: begin
            if (flags.ring_pres) begin
               cmd.op = CMD_P_HEAD;
            end else begin
               cmd.op   = CMD_BASE;
               cmd.emit = 1'b1;
            end
         end
         S_R_RD: cmd.op = CMD_READ;
         S_R_TEST, S_R_CHK: begin
            if (state_ff == S_R_TEST && flags.slot_rdy) begin
               cmd.op = CMD_NXT_P;
            end else if ((state_ff == S_R_TEST && flags.lnq_eq_head)
                         || (state_ff == S_R_CHK && flags.n_max)) begin
               cmd.emit = 1'b1;
               if (flags.op == OP_FINISH) begin
                  cmd.op = CMD_BASE;
               end else begin
                  cmd.status_we = 1'b1;
                  cmd.status    = ST_NOCHANGE;
               end
            end else if (state_ff == S_R_TEST) begin
               cmd.op = CMD_P_LINK_INC;
            end
         end
         S_REL_RD: cmd.op = CMD_READ;
         S_REL_TEST: begin
            cmd.emit = 1'b1;
            if (flags.st_done) begin
               cmd.op = CMD_REL;
            end else begin
               cmd.status_we = 1'b1;
               cmd.status    = ST_NOTDONE;
            end
         end
         default: cmd.op = CMD_NONE;
      endcase
   end

endmodule

FILE: src/prcrr_dpath.sv
// slot memories, ring registers and result registers of the thread scheduler
module prcrr_dpath #(
   parameter int MAX_CORES   = prcrr_pkg::DEF_MAX_CORES,
   parameter int MAX_THREADS = prcrr_pkg::DEF_MAX_THREADS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  prcrr_pkg::req_type     req,
   input  prcrr_pkg::ctl_cmd_type cmd,
   input  logic                   csr_valid,
   input  logic [prcrr_pkg::CFG_W-1:0] csr_data,
   output prcrr_pkg::dp_flags_type flags,
   output logic                   rsp_valid,
   output prcrr_pkg::rsp_type     rsp
);
   import prcrr_pkg::*;

   localparam int CW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int TW   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int NW   = $clog2(MAX_THREADS + 1);
   localparam int NCW  = $clog2(MAX_CORES + 1);
   localparam int CMPW = (NCW > CFG_W) ? NCW : CFG_W;

   logic [1:0]    st_mem [MAX_THREADS];
   logic [TW-1:0] ln_mem [MAX_THREADS];
   logic [MAX_THREADS-1:0] stv_ff;
   logic [1:0]    st_raw;
   logic          stv_q;
   logic [1:0]    st_q;
   logic [TW-1:0] ln_q;

   logic [TW-1:0] head_ff [MAX_CORES];
   logic [TW-1:0] run_ff  [MAX_CORES];
   logic [MAX_CORES-1:0] ring_pres_ff;
   logic [MAX_CORES-1:0] run_pres_ff;

   logic [CFG_W-1:0] ncores_ff;
   logic [CW-1:0]    residue_ff;
   logic [2:0]       op_ff;
   logic [3:0]       core_ff;
   logic [5:0]       tid_ff;
   logic [CW-1:0]    cr_ff;
   logic [TW-1:0]    p_ff, me_ff, nxt_ff, lm_ff;
   logic [NW-1:0]    n_ff;

   logic [2:0] res_status_ff;
   logic [5:0] res_newt_ff, res_swt_ff;
   logic [3:0] res_tgt_ff;
   logic       res_sw_ff, res_base_ff, rsp_valid_ff;

   logic [CMPW-1:0] nc, nc_m1, r_eff, tgt, r_nxt;
   logic [CW-1:0]   cr_in;
   logic [TW-1:0]   ra;
   logic            st_we, ln_we;
   logic [TW-1:0]   st_wa, ln_wa, ln_wd;
   logic [1:0]      st_wd;

   // round robin target
   always_comb begin
      nc    = (CMPW'(ncores_ff) > CMPW'(MAX_CORES)) ? CMPW'(MAX_CORES)
                                                    : CMPW'(ncores_ff);
      nc_m1 = nc - CMPW'(1);
      r_eff = (CMPW'(residue_ff) >= nc_m1) ? '0 : CMPW'(residue_ff);
      tgt   = r_eff + CMPW'(1);
      r_nxt = (tgt >= nc_m1) ? '0 : tgt;
      cr_in = (req.operation == OP_SPAWN) ? CW'(tgt) : CW'(req.core);
   end

   assign st_q = stv_q ? st_raw : SLOT_FREE;
   assign ra   = (cmd.op == CMD_READ_HEAD) ? head_ff[cr_ff] : p_ff;

   // memory write selection
   always_comb begin
      st_we = 1'b0;
      st_wa = p_ff;
      st_wd = SLOT_FREE;
      ln_we = 1'b0;
      ln_wa = p_ff;
      ln_wd = p_ff;
      case (cmd.op)
         CMD_SP_SET: begin
            st_we = 1'b1;
            st_wd = SLOT_READY;
            ln_we = !ring_pres_ff[cr_ff];
         end
         CMD_FIN_DONE: begin
            st_we = 1'b1;
            st_wa = me_ff;
            st_wd = SLOT_DONE;
         end
         CMD_Y_SW1: begin
            st_we = 1'b1;
            st_wa = me_ff;
            st_wd = SLOT_READY;
         end
         CMD_SW_RUN: begin
            st_we = 1'b1;
            st_wa = nxt_ff;
            st_wd = SLOT_RUNNING;
         end
         CMD_REL: begin
            st_we = 1'b1;
            st_wd = SLOT_FREE;
         end
         CMD_SP_LINK1: begin
            ln_we = 1'b1;
            ln_wd = ln_q;
         end
         CMD_SP_LINK2: begin
            ln_we = 1'b1;
            ln_wa = head_ff[cr_ff];
         end
         CMD_FIN_FIX: begin
            ln_we = 1'b1;
            ln_wd = lm_ff;
         end
         default: st_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_wa] <= st_wd;
      if (ln_we) ln_mem[ln_wa] <= ln_wd;
      st_raw <= st_mem[ra];
      ln_q   <= ln_mem[ra];
      stv_q  <= stv_ff[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stv_ff       <= '0;
         ring_pres_ff <= '0;
         run_pres_ff  <= '0;
         ncores_ff    <= CFG_W'(1);
         residue_ff   <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (st_we) stv_ff[st_wa] <= 1'b1;
         if (csr_valid) ncores_ff <= csr_data;
         if (cmd.op == CMD_START && req.operation == OP_SPAWN && nc > CMPW'(1))
            residue_ff <= CW'(r_nxt);
         if (cmd.op == CMD_SP_SET) ring_pres_ff[cr_ff] <= 1'b1;
         if (cmd.op == CMD_FIN_SOLO) ring_pres_ff[cr_ff] <= 1'b0;
         if (cmd.op == CMD_SW_RUN) run_pres_ff[cr_ff] <= 1'b1;
         if (cmd.op == CMD_BASE) run_pres_ff[cr_ff] <= 1'b0;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.status_we) res_status_ff <= cmd.status;
      case (cmd.op)
         CMD_START: begin
            op_ff         <= req.operation;
            core_ff       <= req.core;
            tid_ff        <= req.thread_id;
            cr_ff         <= cr_in;
            me_ff         <= run_ff[CW'(req.core)];
            p_ff          <= '0;
            n_ff          <= '0;
            res_status_ff <= ST_OK;
            res_newt_ff   <= '0;
            res_tgt_ff    <= '0;
            res_sw_ff     <= 1'b0;
            res_swt_ff    <= '0;
            res_base_ff   <= 1'b0;
         end
         CMD_P_INC: p_ff <= p_ff + TW'(1);
         CMD_SP_SET: begin
            res_newt_ff <= 6'(p_ff);
            res_tgt_ff  <= 4'(cr_ff);
            if (!ring_pres_ff[cr_ff]) head_ff[cr_ff] <= p_ff;
         end
         CMD_P_ME, CMD_FIN_DONE: p_ff <= me_ff;
         CMD_P_HEAD: begin
            p_ff <= head_ff[cr_ff];
            n_ff <= '0;
         end
         CMD_P_TID: p_ff <= TW'(tid_ff);
         CMD_P_LINK: begin
            p_ff <= ln_q;
            n_ff <= '0;
         end
         CMD_P_LINK_INC: begin
            p_ff <= ln_q;
            n_ff <= n_ff + NW'(1);
         end
         CMD_FIN_LM: begin
            lm_ff <= ln_q;
            p_ff  <= ln_q;
            n_ff  <= '0;
         end
         CMD_FIN_FIX: begin
            if (head_ff[cr_ff] == me_ff) head_ff[cr_ff] <= lm_ff;
         end
         CMD_Y_SW1, CMD_NXT_P: nxt_ff <= p_ff;
         CMD_SW_RUN: begin
            run_ff[cr_ff] <= nxt_ff;
            res_sw_ff     <= 1'b1;
            res_swt_ff    <= 6'(nxt_ff);
         end
         CMD_BASE: res_base_ff <= 1'b1;
         default: res_base_ff <= res_base_ff;
      endcase
   end

   always_comb begin
      flags.op          = op_ff;
      flags.inv_core    = (32'(core_ff) >= MAX_CORES);
      flags.tid_bad     = (32'(tid_ff) >= MAX_THREADS);
      flags.nc_le1      = (nc <= CMPW'(1));
      flags.run_pres    = run_pres_ff[cr_ff];
      flags.ring_pres   = ring_pres_ff[cr_ff];
      flags.st_free     = (st_q == SLOT_FREE);
      flags.slot_rdy    = (st_q == SLOT_READY);
      flags.st_done     = (st_q == SLOT_DONE);
      flags.p_last      = (p_ff == TW'(MAX_THREADS - 1));
      flags.p_eq_me     = (p_ff == me_ff);
      flags.n_max       = (n_ff == NW'(MAX_THREADS));
      flags.lnq_eq_me   = (ln_q == me_ff);
      flags.lnq_eq_head = (ln_q == head_ff[cr_ff]);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp.status         = res_status_ff;
   assign rsp.new_thread     = res_newt_ff;
   assign rsp.target_core    = res_tgt_ff;
   assign rsp.switch_valid   = res_sw_ff;
   assign rsp.switch_thread  = res_swt_ff;
   assign rsp.return_to_base = res_base_ff;

endmodule

FILE: src/per_core_round_robin_thread_scheduler_unit.sv
// top level of the per core round robin thread scheduler
// Usage: raise start with an item on req while busy is low; the item is taken
// at that edge and busy stays high until the result is issued. The result
// appears on rsp for exactly one cycle, marked by rsp_valid, and every item
// gives exactly one result. The receiver cannot stall the block.
// Some items are settled at decode; a release reads and tests its slot; a
// spawn scans the slot pool for a free slot; yield walks the ring from the
// running thread; finish unlinks the running thread, then finish and tick
// look for a ready thread from the ring head, step by step.
// One item is in flight at a time; the result is shown in an idle cycle and a
// new start is taken at the edge that ends it.
// The csr channel writes the online core count (always ready), used idle.
// Reset: synchronous, active high; all slots free, no rings, no running
// threads, one online core, round robin position one. No clearing pass.
module per_core_round_robin_thread_scheduler_unit #(
   parameter int MAX_CORES   = prcrr_pkg::DEF_MAX_CORES,
   parameter int MAX_THREADS = prcrr_pkg::DEF_MAX_THREADS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  prcrr_pkg::req_type          req,
   output logic                        rsp_valid,
   output prcrr_pkg::rsp_type          rsp,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [prcrr_pkg::CFG_W-1:0] csr_data
);
   import prcrr_pkg::*;

   ctl_cmd_type  cmd;
   dp_flags_type flags;

   assign csr_ready = 1'b1;

   prcrr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .cmd   (cmd),
      .busy  (busy)
   );

   prcrr_dpath #(
      .MAX_CORES   (MAX_CORES),
      .MAX_THREADS (MAX_THREADS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.switch_valid |-> rsp.status == ST_OK && !rsp.return_to_base)
      else $error("switch reported with bad status or base return");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while still busy");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the per core round robin thread scheduler
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import prcrr_pkg::*;

   class sched_scoreboard;
      logic [1:0] slot_st [64];
      logic [5:0] link [64];
      logic [5:0] head [16];
      bit         ring_on [16];
      logic [5:0] run_slot [16];
      bit         run_on [16];
      logic [3:0] residue;
      logic [4:0] cpus;
      rsp_type    pending_rsps [$];
      int         failures;

      function new();
         for (int i = 0; i < 64; i++) begin
            slot_st[i] = SLOT_FREE;
            link[i] = '0;
         end
         for (int c = 0; c < 16; c++) begin
            head[c] = '0;
            ring_on[c] = 1'b0;
            run_slot[c] = '0;
            run_on[c] = 1'b0;
         end
         residue = 4'd1;
         cpus = 5'd1;
         failures = 0;
      endfunction

      function bit first_ready(int c, output logic [5:0] found);
         logic [5:0] p;
         if (!ring_on[c]) return 1'b0;
         p = head[c];
         for (int n = 0; n < 64; n++) begin
            if (slot_st[p] == SLOT_READY) begin
               found = p;
               return 1'b1;
            end
            p = link[p];
            if (p == head[c]) break;
         end
         return 1'b0;
      endfunction

      function rsp_type schedule_event(req_type r);
         rsp_type    o;
         int         nc, rr, c, free_idx;
         logic [5:0] me, p, nxt;
         bit         hit;
         o = '0;
         o.status = ST_OK;
         c = int'(r.core);
         case (r.operation)
            OP_SPAWN: begin
               nc = (cpus > 16) ? 16 : int'(cpus);
               if (nc <= 1) begin
                  o.status = ST_INLINE;
               end else begin
                  rr = int'(residue);
                  if (rr >= nc - 1) rr = 0;
                  o.target_core = 4'(rr + 1);
                  rr = rr + 1;
                  if (rr >= nc - 1) rr = 0;
                  residue = 4'(rr);
                  free_idx = -1;
                  for (int i = 0; i < 64; i++)
                     if (free_idx < 0 && slot_st[i] == SLOT_FREE) free_idx = i;
                  if (free_idx < 0) begin
                     o.status = ST_NOSLOT;
                     o.target_core = '0;
                  end else begin
                     slot_st[free_idx] = SLOT_READY;
                     if (!ring_on[o.target_core]) begin
                        link[free_idx] = 6'(free_idx);
                        head[o.target_core] = 6'(free_idx);
                        ring_on[o.target_core] = 1'b1;
                     end else begin
                        link[free_idx] = link[head[o.target_core]];
                        link[head[o.target_core]] = 6'(free_idx);
                     end
                     o.new_thread = 6'(free_idx);
                  end
               end
            end
            OP_YIELD: begin
               if (!run_on[c]) begin
                  o.status = ST_NOCHANGE;
               end else begin
                  me = run_slot[c];
                  hit = 1'b0;
                  nxt = '0;
                  p = link[me];
                  for (int n = 0; n < 64 && p != me; n++) begin
                     if (slot_st[p] == SLOT_READY) begin
                        hit = 1'b1;
                        nxt = p;
                        break;
                     end
                     p = link[p];
                  end
                  if (!hit) begin
                     o.status = ST_NOCHANGE;
                  end else begin
                     slot_st[me] = SLOT_READY;
                     slot_st[nxt] = SLOT_RUNNING;
                     run_slot[c] = nxt;
                     o.switch_valid = 1'b1;
                     o.switch_thread = nxt;
                  end
               end
            end
            OP_FINISH: begin
               if (!run_on[c]) begin
                  o.status = ST_INVALID;
               end else begin
                  me = run_slot[c];
                  slot_st[me] = SLOT_DONE;
                  if (link[me] == me) begin
                     ring_on[c] = 1'b0;
                  end else begin
                     p = link[me];
                     for (int n = 0; n < 64 && link[p] != me; n++) p = link[p];
                     link[p] = link[me];
                     if (head[c] == me) head[c] = link[me];
                  end
                  if (first_ready(c, nxt)) begin
                     slot_st[nxt] = SLOT_RUNNING;
                     run_slot[c] = nxt;
                     o.switch_valid = 1'b1;
                     o.switch_thread = nxt;
                  end else begin
                     run_on[c] = 1'b0;
                     o.return_to_base = 1'b1;
                  end
               end
            end
            OP_TICK: begin
               if (run_on[c] || !first_ready(c, nxt)) begin
                  o.status = ST_NOCHANGE;
               end else begin
                  slot_st[nxt] = SLOT_RUNNING;
                  run_slot[c] = nxt;
                  run_on[c] = 1'b1;
                  o.switch_valid = 1'b1;
                  o.switch_thread = nxt;
               end
            end
            OP_RELEASE: begin
               if (slot_st[r.thread_id] != SLOT_DONE) o.status = ST_NOTDONE;
               else slot_st[r.thread_id] = SLOT_FREE;
            end
            default: o.status = ST_INVALID;
         endcase
         return o;
      endfunction

      function void note_item(req_type r);
         pending_rsps.push_back(schedule_event(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (pending_rsps.size() == 0) begin
            $error("unexpected result %p", got);
            failures++;
            return;
         end
         exp = pending_rsps.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            failures++;
         end
         if (got.new_thread !== exp.new_thread) begin
            $error("new_thread: expected %0d, got %0d", exp.new_thread, got.new_thread);
            failures++;
         end
         if (got.target_core !== exp.target_core) begin
            $error("target_core: expected %0d, got %0d", exp.target_core, got.target_core);
            failures++;
         end
         if (got.switch_valid !== exp.switch_valid) begin
            $error("switch_valid: expected %0d, got %0d", exp.switch_valid,
                   got.switch_valid);
            failures++;
         end
         if (got.switch_thread !== exp.switch_thread) begin
            $error("switch_thread: expected %0d, got %0d", exp.switch_thread,
                   got.switch_thread);
            failures++;
         end
         if (got.return_to_base !== exp.return_to_base) begin
            $error("return_to_base: expected %0d, got %0d", exp.return_to_base,
                   got.return_to_base);
            failures++;
         end
      endfunction
   endclass

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   req_type        req;
   logic           rsp_valid;
   rsp_type        rsp;
   logic           csr_valid;
   logic           csr_ready;
   logic [CFG_W-1:0] csr_data;

   sched_scoreboard sb;

   per_core_round_robin_thread_scheduler_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp);
   end

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_item(logic [2:0] op, logic [3:0] c, logic [5:0] tid);
      @(negedge clock);
      start <= 1'b1;
      req <= '{operation: op, core: c, thread_id: tid};
      do @(posedge clock); while (busy);
      sb.note_item('{operation: op, core: c, thread_id: tid});
      idle_gap();
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cpu_count(logic [4:0] v);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.cpus = v;
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_data <= CFG_W'($urandom);
   endtask

   task automatic random_items(int count);
      int         nc, pick, k;
      logic [2:0] op;
      logic [3:0] c;
      logic [5:0] tid;
      for (int i = 0; i < count; i++) begin
         nc = (sb.cpus > 16) ? 16 : ((sb.cpus < 2) ? 2 : int'(sb.cpus));
         pick = $urandom_range(0, 99);
         if (pick < 28) op = OP_SPAWN;
         else if (pick < 45) op = OP_YIELD;
         else if (pick < 62) op = OP_FINISH;
         else if (pick < 80) op = OP_TICK;
         else if (pick < 96) op = OP_RELEASE;
         else op = 3'($urandom_range(5, 7));
         c = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, nc - 1));
         tid = 6'($urandom);
         if (op == OP_RELEASE && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, 63);
            for (int j = 0; j < 64; j++)
               if (sb.slot_st[(k + j) % 64] == SLOT_DONE) begin
                  tid = 6'((k + j) % 64);
                  break;
               end
         end
         send_item(op, c, tid);
         if (i == count / 2) drain();
      end
   endtask

   initial begin
      #5ms;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single core: inline spawn and idle cores, then spawns, switches and releases on three cores
      send_item(OP_SPAWN, 4'd0, 6'd0);
      send_item(OP_YIELD, 4'd0, 6'd0);
      send_item(OP_FINISH, 4'd15, 6'd0);
      send_item(OP_TICK, 4'd1, 6'd0);
      send_item(OP_RELEASE, 4'd0, 6'd63);
      send_item(3'd5, 4'd0, 6'd0);
      send_item(3'd6, 4'd15, 6'd21);
      send_item(3'd7, 4'd0, 6'd42);
      write_cpu_count(5'd3);
      send_item(OP_SPAWN, 4'd0, 6'd0);
      send_item(OP_SPAWN, 4'd0, 6'd0);
      send_item(OP_SPAWN, 4'd0, 6'd0);
      send_item(OP_TICK, 4'd1, 6'd0);
      send_item(OP_TICK, 4'd1, 6'd0);
      send_item(OP_YIELD, 4'd1, 6'd0);
      send_item(OP_RELEASE, 4'd0, 6'd1);
      send_item(OP_FINISH, 4'd1, 6'd0);
      send_item(OP_RELEASE, 4'd0, 6'd2);
      send_item(OP_FINISH, 4'd1, 6'd0);
      send_item(OP_TICK, 4'd2, 6'd0);
      send_item(OP_FINISH, 4'd2, 6'd0);
      send_item(OP_RELEASE, 4'd0, 6'd1);

      write_cpu_count(5'd2);
      random_items(150);
      write_cpu_count(5'd16);
      random_items(250);
      write_cpu_count(5'd31);
      random_items(150);
      write_cpu_count(5'd0);
      random_items(40);
      write_cpu_count(5'd1);
      random_items(40);
      write_cpu_count(5'($urandom_range(3, 15)));
      random_items(200);
      write_cpu_count(5'd16);
      random_items(150);

      drain();
      repeat (20) @(posedge clock);
      if (sb.failures == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end
endmodule
